// ----- hw/rtl/text_console_writer_top_assert.svh -----
// Assertion macros used by the console writer checker
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define TCW_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define TCW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tcw_pkg.sv -----
// Types and constants shared by the text console writer modules
package tcw_pkg;

    localparam int FUNC_W = 1;
    localparam int CHAR_W = 8;
    localparam int RROW_W = 5;
    localparam int RCOL_W = 6;
    localparam int CELL_W = 8;
    localparam int OCOL_W = 6;
    localparam int OROW_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_PUT  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_READ = 1'b1;

    localparam logic [CHAR_W-1:0] CODE_CR   = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_LF   = 8'd10;
    localparam logic [CHAR_W-1:0] PRINT_LO  = 8'd32;
    localparam logic [CHAR_W-1:0] PRINT_END = 8'd127;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_FIN
    } tcw_state_t;

    typedef struct packed {
        logic capture;    // latch the input transaction
        logic exec;       // apply the item to cursor, store and read port
        logic sweep_all;  // clear the whole store, one cell a cycle
        logic sweep_row;  // clear the recycled bottom row
        logic load_out;   // load the result register
    } tcw_cmd_t;

    typedef struct packed {
        logic scroll_req; // item at hand pushes the cursor past the last row
        logic all_last;   // full clear reaches its last cell
        logic row_last;   // row clear reaches its last cell
        logic out_free;   // result register can take a new result
    } tcw_status_t;

endpackage

// ----- hw/rtl/text_console_writer_top.sv -----
// Top level of the text console writer: sequencer, datapath and cell store
//
//  channel | direction | payload                                           | handshake
//  s_      | in        | func, char_code, read_row, read_col               | s_valid/s_ready
//  m_      | out       | cell_data, cursor_col_out, cursor_row_out, scrolled | m_valid/m_ready
//
// A put or a read passes through accept, execute (store write or read) and result load.
// A put that scrolls adds a pass that clears the recycled row of the row ring.
// After reset the store is swept to zero, all ROWS*COLS cells (1200 by default);
// s_ready stays low during the sweep. One item is in work at a time; the next
// one is accepted while the previous result waits in the output register.
module text_console_writer_top #(
    parameter int ROWS = 30,
    parameter int COLS = 40
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [tcw_pkg::FUNC_W-1:0] s_func,
    input  logic [tcw_pkg::CHAR_W-1:0] s_char_code,
    input  logic [tcw_pkg::RROW_W-1:0] s_read_row,
    input  logic [tcw_pkg::RCOL_W-1:0] s_read_col,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [tcw_pkg::CELL_W-1:0] m_cell_data,
    output logic [tcw_pkg::OCOL_W-1:0] m_cursor_col_out,
    output logic [tcw_pkg::OROW_W-1:0] m_cursor_row_out,
    output logic                       m_scrolled
);
    import tcw_pkg::*;

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);

    tcw_cmd_t    cmd;
    tcw_status_t status;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    tcw_ctrl u_ctrl (
        .clk     (aclk),
        .rstn    (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcw_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk              (aclk),
        .rstn             (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_func           (s_func),
        .s_char_code      (s_char_code),
        .s_read_row       (s_read_row),
        .s_read_col       (s_read_col),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cell_data      (m_cell_data),
        .m_cursor_col_out (m_cursor_col_out),
        .m_cursor_row_out (m_cursor_row_out),
        .m_scrolled       (m_scrolled),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_re           (ram_re),
        .ram_raddr        (ram_raddr),
        .ram_rdata        (ram_rdata)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ----- hw/rtl/tcw_ram.sv -----
// Generic simple dual-port RAM with registered read
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1200
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/tcw_ctrl.sv -----
// Sequencer of the text console writer: clear pass, execute, scroll, result
module tcw_ctrl (
    input  logic                clk,
    input  logic                rstn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd
);
    import tcw_pkg::*;

    tcw_state_t state_reg;
    tcw_state_t state_next;

    // State register
    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.sweep_all = 1'b1;
                if (status.all_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (status.scroll_req) begin
                    state_next = ST_SCROLL;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SCROLL: begin
                cmd.sweep_row = 1'b1;
                if (status.row_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- hw/rtl/tcw_datapath.sv -----
// Datapath of the text console writer: cursor, row ring, addressing, result
module tcw_datapath #(
    parameter int ROWS = 30,
    parameter int COLS = 40
) (
    input  logic                              clk,
    input  logic                              rstn,
    input  tcw_pkg::tcw_cmd_t                 cmd,
    output tcw_pkg::tcw_status_t              status,
    input  logic [tcw_pkg::FUNC_W-1:0]        s_func,
    input  logic [tcw_pkg::CHAR_W-1:0]        s_char_code,
    input  logic [tcw_pkg::RROW_W-1:0]        s_read_row,
    input  logic [tcw_pkg::RCOL_W-1:0]        s_read_col,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tcw_pkg::CELL_W-1:0]        m_cell_data,
    output logic [tcw_pkg::OCOL_W-1:0]        m_cursor_col_out,
    output logic [tcw_pkg::OROW_W-1:0]        m_cursor_row_out,
    output logic                              m_scrolled,
    output logic                              ram_we,
    output logic [$clog2(ROWS*COLS)-1:0]      ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0]        ram_wdata,
    output logic                              ram_re,
    output logic [$clog2(ROWS*COLS)-1:0]      ram_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]        ram_rdata
);
    import tcw_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int AW = $clog2(ROWS * COLS);

    // Captured transaction
    logic [FUNC_W-1:0] func_reg;
    logic [CHAR_W-1:0] code_reg;
    logic [RROW_W-1:0] rrow_reg;
    logic [RCOL_W-1:0] rcol_reg;

    // Cursor and ring of rows: top_reg is the physical row shown on top
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [RW-1:0] top_reg, top_next;

    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] base_reg;
    logic          hit_reg;
    logic          scr_reg;

    logic              m_valid_reg;
    logic [CELL_W-1:0] cell_reg;
    logic [OCOL_W-1:0] ocol_reg;
    logic [OROW_W-1:0] orow_reg;
    logic              oscr_reg;

    logic          is_read, is_cr, is_lf, is_print;
    logic          col_last, row_last, adv, scroll_req, in_range;
    logic [RW:0]   cur_sum, rd_sum;
    logic [RW-1:0] cur_prow, rd_prow;
    logic [AW-1:0] cur_addr, rd_addr;
    logic [7:0]    col_wide, row_wide;

    // Decode the captured item
    assign is_read    = (func_reg == FUNC_READ);
    assign is_cr      = (code_reg == CODE_CR);
    assign is_lf      = (code_reg == CODE_LF);
    assign is_print   = (code_reg >= PRINT_LO) && (code_reg < PRINT_END);
    assign col_last   = (col_reg == CW'(COLS - 1));
    assign row_last   = (row_reg == RW'(ROWS - 1));
    assign adv        = !is_read && (is_lf || (is_print && col_last));
    assign scroll_req = adv && row_last;
    assign in_range   = (7'(rrow_reg) < 7'(ROWS)) && (8'(rcol_reg) < 8'(COLS));

    // Map screen rows to physical rows through the ring offset
    assign cur_sum  = {1'b0, top_reg} + {1'b0, row_reg};
    assign cur_prow = (cur_sum >= (RW + 1)'(ROWS)) ? RW'(cur_sum - (RW + 1)'(ROWS))
                                                   : RW'(cur_sum);
    assign cur_addr = AW'(cur_prow) * AW'(COLS) + AW'(col_reg);

    assign rd_sum  = {1'b0, top_reg} + {1'b0, RW'(rrow_reg)};
    assign rd_prow = (rd_sum >= (RW + 1)'(ROWS)) ? RW'(rd_sum - (RW + 1)'(ROWS))
                                                 : RW'(rd_sum);
    assign rd_addr = AW'(rd_prow) * AW'(COLS) + AW'(rcol_reg);

    // Store write port: full clear, row clear or character write
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = code_reg;
        if (cmd.sweep_all) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg;
            ram_wdata = '0;
        end else if (cmd.sweep_row) begin
            ram_we    = 1'b1;
            ram_waddr = base_reg + cnt_reg;
            ram_wdata = '0;
        end else if (cmd.exec && !is_read && is_print) begin
            ram_we = 1'b1;
        end
    end

    assign ram_re    = cmd.exec && is_read && in_range;
    assign ram_raddr = rd_addr;

    // Cursor, ring offset and sweep counter updates
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        top_next = top_reg;
        cnt_next = '0;
        if (cmd.sweep_all || cmd.sweep_row) begin
            cnt_next = cnt_reg + AW'(1);
        end
        if (cmd.exec && !is_read) begin
            if (is_cr || is_lf) begin
                col_next = '0;
            end else if (is_print) begin
                col_next = col_last ? '0 : col_reg + CW'(1);
            end
            if (adv && !row_last) begin
                row_next = row_reg + RW'(1);
            end
            if (scroll_req) begin
                top_next = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + RW'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk) begin
        if (!rstn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            top_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            top_reg <= top_next;
            cnt_reg <= cnt_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            func_reg <= s_func;
            code_reg <= s_char_code;
            rrow_reg <= s_read_row;
            rcol_reg <= s_read_col;
        end
        if (cmd.exec) begin
            hit_reg  <= is_read && in_range;
            scr_reg  <= scroll_req;
            base_reg <= AW'(top_reg) * AW'(COLS);
        end
        if (cmd.load_out) begin
            cell_reg <= hit_reg ? ram_rdata : '0;
            ocol_reg <= col_wide[OCOL_W-1:0];
            orow_reg <= row_wide[OROW_W-1:0];
            oscr_reg <= scr_reg;
        end
    end

    assign col_wide = 8'(col_reg);
    assign row_wide = 8'(row_reg);

    // Status toward the sequencer
    assign status.scroll_req = scroll_req;
    assign status.all_last   = (cnt_reg == AW'(ROWS * COLS - 1));
    assign status.row_last   = (cnt_reg == AW'(COLS - 1));
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_cell_data      = cell_reg;
    assign m_cursor_col_out = ocol_reg;
    assign m_cursor_row_out = orow_reg;
    assign m_scrolled       = oscr_reg;

endmodule

// ----- hw/rtl/tcw_checker.sv -----
// Port-level assertions for the text console writer and their bind
`include "text_console_writer_top_assert.svh"

module tcw_checker #(
    parameter int ROWS = 30,
    parameter int COLS = 40
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [tcw_pkg::CELL_W-1:0] m_cell_data,
    input logic [tcw_pkg::OCOL_W-1:0] m_cursor_col_out,
    input logic [tcw_pkg::OROW_W-1:0] m_cursor_row_out,
    input logic                       m_scrolled
);
    import tcw_pkg::*;

    localparam logic [OROW_W-1:0] LAST_ROW = OROW_W'((ROWS - 1) % 32);

    // A stalled result holds its cell data, cursor column and scroll flag still
    `TCW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_cell_data) && $stable(m_cursor_col_out) && $stable(m_scrolled), "result changed while stalled")

    // Only one item is in work: no accept right after an accept
    `TCW_ASSERT_NEXT(a_one_in_work, aclk, aresetn, s_valid && s_ready, !s_ready, "accepted two items back to back")

    // A scroll leaves the cursor at column zero of the last row, on a put
    `TCW_ASSERT_SAME(a_scroll_cursor, aclk, aresetn, m_valid && m_scrolled, (m_cursor_row_out == LAST_ROW) && (m_cursor_col_out == '0) && (m_cell_data == '0), "scroll result has wrong cursor or data")

    // A stalled result stays valid while s_ready is low
    `TCW_ASSERT_NEXT(a_no_overrun, aclk, aresetn, m_valid && !m_ready && !s_ready, m_valid, "result dropped without handshake")

endmodule

bind text_console_writer_top tcw_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_cell_data      (m_cell_data),
    .m_cursor_col_out (m_cursor_col_out),
    .m_cursor_row_out (m_cursor_row_out),
    .m_scrolled       (m_scrolled)
);
